@@ rtl/pgt_pkg.sv @@
// ----------------------------------------------------------------------------
// pgt_pkg
// Shared types, widths, event codes and controller states of the pinch
// gesture tracker.
// ----------------------------------------------------------------------------
package pgt_pkg;

    // Build constants.
    localparam int MAX_POINTS      = 5;
    localparam int COORD_BITS      = 12;

    // Fixed field widths of the ports.
    localparam int PORT_POINTS     = 5;
    localparam int PORT_COORD_W    = 12;
    localparam int CFG_W           = 12;
    localparam int CFG_IDX_W       = 2;
    localparam int KIND_W          = 3;
    localparam int PCOUNT_W        = 4;
    localparam int ACTIVE_W        = 3;
    localparam int EVT_W           = 16;
    localparam int DIST_W          = 13;
    localparam int SCALE_W         = 15;

    // Datapath widths.
    localparam int PT_IDX_W        = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int SQ_W            = 2 * PORT_COORD_W + 1;
    localparam int ROOT_W          = (SQ_W + 1) / 2;
    localparam int QUO_W           = 20;
    localparam int SQ_STEPS        = PORT_COORD_W;
    localparam int ROOT_STEPS      = ROOT_W;
    localparam int DIV_STEPS       = QUO_W;
    localparam int SQ_CNT_W        = $clog2(SQ_STEPS);
    localparam int ROOT_CNT_W      = $clog2(ROOT_STEPS);
    localparam int DIV_CNT_W       = $clog2(DIV_STEPS);

    typedef logic [PORT_COORD_W-1:0] coord_t;
    typedef logic [KIND_W-1:0]       kind_t;

    localparam coord_t COORD_MASK = PORT_COORD_W'((64'd1 << COORD_BITS) - 64'd1);

    // Event codes.
    localparam kind_t KIND_DOWN   = 3'd0;
    localparam kind_t KIND_UP     = 3'd1;
    localparam kind_t KIND_MOVE   = 3'd2;
    localparam kind_t KIND_CANCEL = 3'd3;
    localparam kind_t KIND_PDOWN  = 3'd4;
    localparam kind_t KIND_PUP    = 3'd5;
    localparam kind_t KIND_OTHER  = 3'd6;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LEFT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd3;

    localparam logic [SCALE_W-1:0] SCALE_INIT = 15'd100;
    localparam logic [SCALE_W-1:0] SCALE_MAX  = 15'h7FFF;
    localparam logic [QUO_W-1:0]   PCT_MUL    = 20'd100;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_SQR,
        ST_ROOT,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

@@ rtl/pgt_sqsum.sv @@
// ----------------------------------------------------------------------------
// pgt_sqsum
// Bit-serial sum of squares dx*dx + dy*dy, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module pgt_sqsum (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  pgt_pkg::coord_t           dx,
    input  pgt_pkg::coord_t           dy,
    output logic                      done,
    output logic [pgt_pkg::SQ_W-1:0]  sum
);
    import pgt_pkg::*;

    localparam logic [SQ_CNT_W-1:0] LAST = SQ_CNT_W'(SQ_STEPS - 1);

    logic                    busy_reg;
    logic                    done_reg;
    logic [SQ_CNT_W-1:0]     cnt_reg;
    coord_t                  ax_reg;
    coord_t                  ay_reg;
    coord_t                  mx_reg;
    coord_t                  my_reg;
    logic [PORT_COORD_W:0]   hi_reg;
    coord_t                  lo_reg;
    logic [PORT_COORD_W+1:0] step_sum;

    // The high half takes both partial products; the low half collects the
    // bits that fall out of it.
    always_comb
    begin
        step_sum = (PORT_COORD_W+2)'(hi_reg)
                 + (PORT_COORD_W+2)'(mx_reg[0] ? ax_reg : '0)
                 + (PORT_COORD_W+2)'(my_reg[0] ? ay_reg : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == LAST);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ax_reg <= dx;
            ay_reg <= dy;
            mx_reg <= dx;
            my_reg <= dy;
            hi_reg <= '0;
            lo_reg <= '0;
        end
        else if (busy_reg)
        begin
            mx_reg <= mx_reg >> 1;
            my_reg <= my_reg >> 1;
            hi_reg <= step_sum[PORT_COORD_W+1:1];
            lo_reg <= {step_sum[0], lo_reg[PORT_COORD_W-1:1]};
        end
    end

    assign done = done_reg;
    assign sum  = {hi_reg, lo_reg};

endmodule

@@ rtl/pgt_isqrt.sv @@
// ----------------------------------------------------------------------------
// pgt_isqrt
// Integer square root, one result bit (two radicand bits) per cycle.
// ----------------------------------------------------------------------------
module pgt_isqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pgt_pkg::SQ_W-1:0]    radicand,
    output logic                        done,
    output logic [pgt_pkg::ROOT_W-1:0]  root
);
    import pgt_pkg::*;

    localparam logic [ROOT_CNT_W-1:0] LAST = ROOT_CNT_W'(ROOT_STEPS - 1);

    logic                    busy_reg;
    logic                    done_reg;
    logic [ROOT_CNT_W-1:0]   cnt_reg;
    logic [2*ROOT_W-1:0]     rad_reg;
    logic [ROOT_W:0]         rem_reg;
    logic [ROOT_W-1:0]       root_reg;
    logic [ROOT_W+2:0]       cur;
    logic [ROOT_W+2:0]       trial;
    logic                    fits;

    always_comb
    begin
        cur   = {rem_reg, rad_reg[2*ROOT_W-1 -: 2]};
        trial = (ROOT_W+3)'({root_reg, 2'b01});
        fits  = (cur >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == LAST);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // The remainder never exceeds twice the partial root, so it fits in
    // one bit more than the root.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= (2*ROOT_W)'(radicand);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= rad_reg << 2;
            if (fits)
            begin
                rem_reg  <= (ROOT_W+1)'(cur - trial);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= (ROOT_W+1)'(cur);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

@@ rtl/pgt_div.sv @@
// ----------------------------------------------------------------------------
// pgt_div
// Restoring divider for live * 100 / start, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pgt_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pgt_pkg::DIST_W-1:0]  live,
    input  logic [pgt_pkg::DIST_W-1:0]  divisor,
    output logic                        done,
    output logic [pgt_pkg::QUO_W-1:0]   quo
);
    import pgt_pkg::*;

    localparam logic [DIV_CNT_W-1:0] LAST = DIV_CNT_W'(DIV_STEPS - 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [QUO_W-1:0]      num_reg;
    logic [DIST_W-1:0]     den_reg;
    logic [DIST_W-1:0]     rem_reg;
    logic [DIST_W:0]       trial;
    logic                  fits;

    always_comb
    begin
        trial = {rem_reg, num_reg[QUO_W-1]};
        fits  = (trial >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == LAST);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // Dividend bits leave at the top of num_reg while quotient bits enter
    // at the bottom.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= QUO_W'(live) * PCT_MUL;
            den_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= DIST_W'(trial - {1'b0, den_reg});
            end
            else
            begin
                rem_reg <= trial[DIST_W-1:0];
            end
            num_reg <= {num_reg[QUO_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = num_reg;

endmodule

@@ rtl/pinch_gesture_tracker_core.sv @@
// ----------------------------------------------------------------------------
// pinch_gesture_tracker_core
// Touch event tracker that filters points against a canvas rectangle and
// measures a two-finger pinch distance and scale.
// An accepted word is scanned point by point; a pointer-down or move
// with two or more points inside also runs the sum of squares and root,
// and a move with a start distance also runs the divider for the scale.
// One event is in work at a time. Reset clears the controller, the
// canvas setting and the tracker state, sets the scale to 100 and the
// recorded kind to other.
// ----------------------------------------------------------------------------
module pinch_gesture_tracker_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [pgt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pgt_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [pgt_pkg::KIND_W-1:0]      event_kind,
    input  logic [pgt_pkg::PCOUNT_W-1:0]    touch_count,
    input  pgt_pkg::coord_t                 px0,
    input  pgt_pkg::coord_t                 py0,
    input  pgt_pkg::coord_t                 px1,
    input  pgt_pkg::coord_t                 py1,
    input  pgt_pkg::coord_t                 px2,
    input  pgt_pkg::coord_t                 py2,
    input  pgt_pkg::coord_t                 px3,
    input  pgt_pkg::coord_t                 py3,
    input  pgt_pkg::coord_t                 px4,
    input  pgt_pkg::coord_t                 py4,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            handled,
    output logic                            tracking_now,
    output logic                            pinching_now,
    output logic [pgt_pkg::ACTIVE_W-1:0]    points_in_canvas,
    output logic [pgt_pkg::EVT_W-1:0]       events_seen,
    output logic [pgt_pkg::KIND_W-1:0]      recent_kind,
    output logic [pgt_pkg::DIST_W-1:0]      current_distance,
    output logic [pgt_pkg::SCALE_W-1:0]     scale_out
);
    import pgt_pkg::*;

    localparam logic [PT_IDX_W-1:0] SCAN_LAST = PT_IDX_W'(MAX_POINTS - 1);
    localparam logic [ACTIVE_W-1:0] MAX_CNT   = ACTIVE_W'(MAX_POINTS);

    // Configuration.
    coord_t canvas_left_reg;
    coord_t canvas_top_reg;
    coord_t canvas_width_reg;
    coord_t canvas_height_reg;

    // Controller.
    state_t state_reg;
    state_t state_next;
    logic   accept;
    logic   scan_en;
    logic   scan_last;
    logic   sq_start;
    logic   rt_start;
    logic   dv_start;
    logic   commit;
    logic   out_free;

    // Event being worked on.
    kind_t                 kind_reg;
    logic [ACTIVE_W-1:0]   cnt_lim_reg;
    coord_t                pts_x_reg [0:MAX_POINTS-1];
    coord_t                pts_y_reg [0:MAX_POINTS-1];
    logic [PT_IDX_W-1:0]   scan_idx_reg;
    logic [ACTIVE_W-1:0]   n_in_reg;
    coord_t                x0_reg;
    coord_t                y0_reg;
    coord_t                x1_reg;
    coord_t                y1_reg;
    coord_t                all_x [0:PORT_POINTS-1];
    coord_t                all_y [0:PORT_POINTS-1];
    logic [ACTIVE_W-1:0]   cnt_lim;
    logic                  in_rect;
    logic [PORT_COORD_W:0] right_edge;
    logic [PORT_COORD_W:0] bottom_edge;

    // Tracker state.
    logic                  tracking_reg;
    logic                  tracking_next;
    logic                  pinching_reg;
    logic                  pinching_next;
    logic [ACTIVE_W-1:0]   active_reg;
    logic [ACTIVE_W-1:0]   active_next;
    logic [EVT_W-1:0]      evt_cnt_reg;
    logic [EVT_W-1:0]      evt_cnt_next;
    kind_t                 last_kind_reg;
    kind_t                 last_kind_next;
    logic [DIST_W-1:0]     start_dist_reg;
    logic [DIST_W-1:0]     start_dist_next;
    logic [DIST_W-1:0]     live_dist_reg;
    logic [DIST_W-1:0]     live_dist_next;
    logic [SCALE_W-1:0]    scale_reg;
    logic [SCALE_W-1:0]    scale_next;

    // Decisions.
    logic                  handled_c;
    logic                  need_dist;
    logic                  want_div;
    coord_t                dx;
    coord_t                dy;
    logic [DIST_W-1:0]     dist_min1;
    logic [SCALE_W-1:0]    scale_sat;

    // Serial units.
    logic                  sq_done;
    logic [SQ_W-1:0]       sq_sum;
    logic                  rt_done;
    logic [ROOT_W-1:0]     rt_root;
    logic                  dv_done;
    logic [QUO_W-1:0]      dv_quo;

    // Output word.
    logic                  out_valid_reg;
    logic                  handled_reg;
    logic                  tracking_out_reg;
    logic                  pinching_out_reg;
    logic [ACTIVE_W-1:0]   active_out_reg;
    logic [EVT_W-1:0]      evt_out_reg;
    kind_t                 kind_out_reg;
    logic [DIST_W-1:0]     dist_out_reg;
    logic [SCALE_W-1:0]    scale_out_reg;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canvas_left_reg   <= '0;
            canvas_top_reg    <= '0;
            canvas_width_reg  <= '0;
            canvas_height_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LEFT:   canvas_left_reg   <= cfg_data;
                REG_TOP:    canvas_top_reg    <= cfg_data;
                REG_WIDTH:  canvas_width_reg  <= cfg_data;
                REG_HEIGHT: canvas_height_reg <= cfg_data;
                default:    canvas_left_reg   <= canvas_left_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Controller
    // ------------------------------------------------------------------
    assign out_free  = !out_valid_reg || !out_stall;
    assign scan_last = (scan_idx_reg == SCAN_LAST);

    always_comb
    begin
        handled_c = (kind_reg == KIND_DOWN) ? (n_in_reg != '0) : tracking_reg;
        need_dist = handled_c && (n_in_reg >= ACTIVE_W'(2))
                 && ((kind_reg == KIND_MOVE) || (kind_reg == KIND_PDOWN));
        want_div  = (kind_reg == KIND_MOVE) && (start_dist_reg != '0);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = need_dist ? ST_SQR : ST_DONE;
            end
            ST_SQR:
            begin
                if (sq_done)
                begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (rt_done)
                begin
                    state_next = want_div ? ST_DIV : ST_DONE;
                end
            end
            ST_DIV:
            begin
                if (dv_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall = (state_reg != ST_IDLE);
        accept   = (state_reg == ST_IDLE) && in_valid;
        scan_en  = (state_reg == ST_SCAN);
        sq_start = (state_reg == ST_DECIDE) && need_dist;
        rt_start = (state_reg == ST_SQR) && sq_done;
        dv_start = (state_reg == ST_ROOT) && rt_done && want_div;
        commit   = (state_reg == ST_DONE) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Point scan: the points shift past one inside test, one per cycle
    // ------------------------------------------------------------------
    always_comb
    begin
        all_x = '{px0, px1, px2, px3, px4};
        all_y = '{py0, py1, py2, py3, py4};
        if (touch_count > PCOUNT_W'(MAX_POINTS))
        begin
            cnt_lim = MAX_CNT;
        end
        else
        begin
            cnt_lim = touch_count[ACTIVE_W-1:0];
        end
        right_edge  = {1'b0, canvas_left_reg} + {1'b0, canvas_width_reg};
        bottom_edge = {1'b0, canvas_top_reg} + {1'b0, canvas_height_reg};
        // An empty width or height makes the half-open range empty.
        in_rect = (ACTIVE_W'(scan_idx_reg) < cnt_lim_reg)
               && (pts_x_reg[0] >= canvas_left_reg)
               && ({1'b0, pts_x_reg[0]} < right_edge)
               && (pts_y_reg[0] >= canvas_top_reg)
               && ({1'b0, pts_y_reg[0]} < bottom_edge);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            n_in_reg     <= '0;
        end
        else if (accept)
        begin
            scan_idx_reg <= '0;
            n_in_reg     <= '0;
        end
        else if (scan_en)
        begin
            if (!scan_last)
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
            if (in_rect)
            begin
                n_in_reg <= n_in_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg    <= event_kind;
            cnt_lim_reg <= cnt_lim;
            for (int i = 0; i < MAX_POINTS; i++)
            begin
                pts_x_reg[i] <= all_x[i] & COORD_MASK;
                pts_y_reg[i] <= all_y[i] & COORD_MASK;
            end
        end
        else if (scan_en)
        begin
            for (int i = 0; i < MAX_POINTS - 1; i++)
            begin
                pts_x_reg[i] <= pts_x_reg[i+1];
                pts_y_reg[i] <= pts_y_reg[i+1];
            end
            if (in_rect && (n_in_reg == ACTIVE_W'(0)))
            begin
                x0_reg <= pts_x_reg[0];
                y0_reg <= pts_y_reg[0];
            end
            if (in_rect && (n_in_reg == ACTIVE_W'(1)))
            begin
                x1_reg <= pts_x_reg[0];
                y1_reg <= pts_y_reg[0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Distance and scale units
    // ------------------------------------------------------------------
    assign dx = (x0_reg > x1_reg) ? (x0_reg - x1_reg) : (x1_reg - x0_reg);
    assign dy = (y0_reg > y1_reg) ? (y0_reg - y1_reg) : (y1_reg - y0_reg);

    pgt_sqsum u_sqsum (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .dx       (dx),
        .dy       (dy),
        .done     (sq_done),
        .sum      (sq_sum)
    );

    pgt_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rt_start),
        .radicand (sq_sum),
        .done     (rt_done),
        .root     (rt_root)
    );

    pgt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dv_start),
        .live     (DIST_W'(rt_root)),
        .divisor  (start_dist_reg),
        .done     (dv_done),
        .quo      (dv_quo)
    );

    // ------------------------------------------------------------------
    // State update at commit
    // ------------------------------------------------------------------
    always_comb
    begin
        dist_min1 = (rt_root == '0) ? DIST_W'(1) : DIST_W'(rt_root);
        if (dv_quo > QUO_W'(SCALE_MAX))
        begin
            scale_sat = SCALE_MAX;
        end
        else
        begin
            scale_sat = dv_quo[SCALE_W-1:0];
        end

        tracking_next   = tracking_reg;
        pinching_next   = pinching_reg;
        active_next     = active_reg;
        evt_cnt_next    = evt_cnt_reg;
        last_kind_next  = last_kind_reg;
        start_dist_next = start_dist_reg;
        live_dist_next  = live_dist_reg;
        scale_next      = scale_reg;

        if ((kind_reg == KIND_DOWN) && (n_in_reg == '0))
        begin
            tracking_next = 1'b0;
        end
        else if (handled_c)
        begin
            tracking_next  = 1'b1;
            evt_cnt_next   = evt_cnt_reg + 1'b1;
            last_kind_next = kind_reg;
            active_next    = n_in_reg;
            case (kind_reg)
                KIND_DOWN:
                begin
                    pinching_next   = 1'b0;
                    start_dist_next = '0;
                    live_dist_next  = '0;
                    scale_next      = SCALE_INIT;
                end
                KIND_MOVE:
                begin
                    if (need_dist)
                    begin
                        live_dist_next = DIST_W'(rt_root);
                        if (want_div)
                        begin
                            scale_next = scale_sat;
                        end
                    end
                end
                KIND_PDOWN:
                begin
                    if (need_dist)
                    begin
                        pinching_next   = 1'b1;
                        start_dist_next = dist_min1;
                        live_dist_next  = dist_min1;
                        scale_next      = SCALE_INIT;
                    end
                end
                KIND_PUP:
                begin
                    pinching_next = 1'b0;
                    if (n_in_reg > ACTIVE_W'(1))
                    begin
                        active_next = n_in_reg - 1'b1;
                    end
                end
                KIND_UP, KIND_CANCEL:
                begin
                    tracking_next = 1'b0;
                    pinching_next = 1'b0;
                    active_next   = '0;
                end
                default:
                begin
                    active_next = n_in_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tracking_reg   <= 1'b0;
            pinching_reg   <= 1'b0;
            active_reg     <= '0;
            evt_cnt_reg    <= '0;
            last_kind_reg  <= KIND_OTHER;
            start_dist_reg <= '0;
            live_dist_reg  <= '0;
            scale_reg      <= SCALE_INIT;
        end
        else if (commit)
        begin
            tracking_reg   <= tracking_next;
            pinching_reg   <= pinching_next;
            active_reg     <= active_next;
            evt_cnt_reg    <= evt_cnt_next;
            last_kind_reg  <= last_kind_next;
            start_dist_reg <= start_dist_next;
            live_dist_reg  <= live_dist_next;
            scale_reg      <= scale_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            handled_reg      <= handled_c;
            tracking_out_reg <= tracking_next;
            pinching_out_reg <= pinching_next;
            active_out_reg   <= active_next;
            evt_out_reg      <= evt_cnt_next;
            kind_out_reg     <= last_kind_next;
            dist_out_reg     <= live_dist_next;
            scale_out_reg    <= scale_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign handled          = handled_reg;
    assign tracking_now     = tracking_out_reg;
    assign pinching_now     = pinching_out_reg;
    assign points_in_canvas = active_out_reg;
    assign events_seen      = evt_out_reg;
    assign recent_kind      = kind_out_reg;
    assign current_distance = dist_out_reg;
    assign scale_out        = scale_out_reg;

`ifndef SYNTHESIS
    // An unhandled event leaves the event counter alone.
    assert property (@(posedge clk) disable iff (!rst_n)
        commit && !handled_c |=> $stable(evt_cnt_reg))
        else $error("event counter moved on an unhandled event");

    // A pinch always has a nonzero start distance to divide by.
    assert property (@(posedge clk) disable iff (!rst_n)
        pinching_reg |-> (start_dist_reg != '0))
        else $error("pinch active with zero start distance");

    assert property (@(posedge clk) disable iff (!rst_n)
        dv_start |-> (start_dist_reg != '0))
        else $error("divider started with zero divisor");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (active_out_reg <= MAX_CNT))
        else $error("active point count beyond the point limit");
`endif

endmodule
